/* sv/rrgs_pkg.sv */
// shared types and constants of the rounded rectangle span unit
package rrgs_pkg;

  // number of square root and divide steps, one per cell
  localparam int unsigned NUM_STEPS = 11;

  // register indexes
  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_RADIUS  = 3'd2;
  localparam logic [2:0] REG_STYLES  = 3'd3;
  localparam logic [2:0] REG_C_FROM  = 3'd4;
  localparam logic [2:0] REG_C_TO    = 3'd5;
  localparam logic [2:0] REG_CLIP_C  = 3'd6;
  localparam logic [2:0] REG_CLIP_R  = 3'd7;

  // corner style codes
  localparam logic [1:0] STYLE_SQUARE = 2'd0;
  localparam logic [1:0] STYLE_MITRE  = 2'd1;

  typedef enum logic [1:0] {
    ST_DRAW  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OUT   = 2'd2
  } span_status_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_MITRE = 2'd1,
    MODE_ROUND = 2'd2
  } inset_mode_t;

  // state of one row as it moves down the chain of cells
  typedef struct packed {
    logic        st2;
    inset_mode_t lmode;
    inset_mode_t rmode;
    logic [10:0] dyl;
    logic [10:0] dyr;
    logic [21:0] vl;
    logic [21:0] vr;
    logic [13:0] reml;
    logic [12:0] rootl;
    logic [13:0] remr;
    logic [12:0] rootr;
    logic [19:0] num;
    logic [10:0] quo;
  } item_t;

endpackage

/* sv/rrgs_if.sv */
// valid/ready channels for row requests and span results
interface rrgs_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] row_index;

  modport source (output valid, output row_index, input ready);
  modport sink (input valid, input row_index, output ready);
endinterface

interface rrgs_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] span_start;
  logic [12:0] span_end;
  logic [23:0] row_color;
  logic [1:0]  span_status;

  modport source (output valid, output span_start, output span_end, output row_color,
                  output span_status, input ready);
  modport sink (input valid, input span_start, input span_end, input row_color,
                input span_status, output ready);
endinterface

/* sv/rounded_rect_gradient_spans_unit.sv */
// rounded rectangle gradient span generator, top level
//
// A row index enters on in_ch; one result leaves on out_ch for every row:
// the first drawn column, the column after the last one, the gradient colour
// of the row and a status (draw, row empty, outside buffer or rectangle).
// Shape and colour are set through the write port (cfg_we, cfg_index,
// cfg_wdata), by the user only while no row is in flight (not enforced).
// The datapath is a pipeline of 15 register stages: row decode, corner
// multiplies, a chain of 11 cells each doing one square root step for both
// corners and one step of the t = row*255/(h-1) divide, colour mix and
// insets, and the output register. One row can be taken per cycle as long
// as the receiver takes results.
// Each stage advances when it is empty or the one after it advances, so
// bubbles close up; when the receiver stalls, rows keep entering until the
// pipeline is full, and then in_ch.ready falls.
// Reset (rst, synchronous) empties the pipeline and sets the configuration
// registers to zero except the clip limits, which go to MAX_DIM.
module rounded_rect_gradient_spans_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  rrgs_in_if.sink     in_ch,
  rrgs_out_if.source  out_ch
);
  import rrgs_pkg::*;

  localparam int unsigned NSTG = NUM_STEPS + 4;

  // configuration registers
  logic [11:0] rect_width, rect_height;
  logic [10:0] corner_radius;
  logic [7:0]  corner_styles;
  logic [23:0] color_from, color_to;
  logic [12:0] clip_cols, clip_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_width    <= '0;
      rect_height   <= '0;
      corner_radius <= '0;
      corner_styles <= '0;
      color_from    <= '0;
      color_to      <= '0;
      clip_cols     <= 13'(MAX_DIM);
      clip_rows     <= 13'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  rect_width    <= cfg_wdata[11:0];
        REG_HEIGHT: rect_height   <= cfg_wdata[11:0];
        REG_RADIUS: corner_radius <= cfg_wdata[10:0];
        REG_STYLES: corner_styles <= cfg_wdata[7:0];
        REG_C_FROM: color_from    <= cfg_wdata;
        REG_C_TO:   color_to      <= cfg_wdata;
        REG_CLIP_C: clip_cols     <= cfg_wdata[12:0];
        REG_CLIP_R: clip_rows     <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // values derived from the registers only
  logic [12:0] ccols, crows;
  logic [10:0] rc;
  logic [11:0] hm1;

  always_comb begin
    ccols = (32'(clip_cols) > MAX_DIM) ? 13'(MAX_DIM) : clip_cols;
    crows = (32'(clip_rows) > MAX_DIM) ? 13'(MAX_DIM) : clip_rows;
    rc    = corner_radius;
    if (rc > rect_width[11:1])
      rc = rect_width[11:1];
    if (rc > rect_height[11:1])
      rc = rect_height[11:1];
    hm1 = rect_height - 12'd1;
  end

  // stage handshake: a stage loads when empty or when its successor loads
  logic                 vld_a, vld_b, vld_m, vld_o;
  logic [NUM_STEPS-1:0] vld_c;
  logic [NSTG-1:0]      vld, en;

  assign vld = {vld_o, vld_m, vld_c, vld_b, vld_a};

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ch.ready = en[0];

  // row decode into corner modes and depths
  item_t       a_nxt, a_q, b_nxt, b_q;
  logic [11:0] row;
  logic [11:0] depth;
  logic [1:0]  lsty, rsty;
  logic        in_top, in_bot;

  function automatic inset_mode_t mode_of(input logic [1:0] sty);
    inset_mode_t m;
    if (sty == STYLE_SQUARE)
      m = MODE_NONE;
    else if (sty == STYLE_MITRE)
      m = MODE_MITRE;
    else
      m = MODE_ROUND;
    return m;
  endfunction

  always_comb begin
    row    = in_ch.row_index;
    a_nxt  = '0;
    a_nxt.st2 = (rect_width == '0) || (rect_height == '0) || (row >= rect_height)
                || (13'(row) >= crows);
    in_top = (rc != '0) && (row < 12'(rc));
    in_bot = (rc != '0) && !in_top && (13'(row) + 13'(rc) >= 13'(rect_height));
    depth  = '0;
    lsty   = STYLE_SQUARE;
    rsty   = STYLE_SQUARE;
    if (in_top) begin
      depth = row;
      lsty  = corner_styles[1:0];
      rsty  = corner_styles[3:2];
    end else if (in_bot) begin
      depth = hm1 - row;
      lsty  = corner_styles[7:6];
      rsty  = corner_styles[5:4];
    end
    a_nxt.lmode = (in_top || in_bot) ? mode_of(lsty) : MODE_NONE;
    a_nxt.rmode = (in_top || in_bot) ? mode_of(rsty) : MODE_NONE;
    a_nxt.dyl   = rc - depth[10:0];
    a_nxt.dyr   = rc - depth[10:0];
    a_nxt.num   = {row, 8'd0} - 20'(row);
  end

  // corner multiplies: r*r - dy*dy per side
  always_comb begin
    b_nxt    = a_q;
    b_nxt.vl = 22'(rc) * 22'(rc) - 22'(a_q.dyl) * 22'(a_q.dyl);
    b_nxt.vr = 22'(rc) * 22'(rc) - 22'(a_q.dyr) * 22'(a_q.dyr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (en[0])
        vld_a <= in_ch.valid;
      if (en[1])
        vld_b <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0])
      a_q <= a_nxt;
    if (en[1])
      b_q <= b_nxt;
  end

  // chain of root and divide cells
  item_t cq [NUM_STEPS+1];
  assign cq[0] = b_q;

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_cell
    rrgs_cell #(.STEP(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en[k+2]),
      .vld_in  (vld[k+1]),
      .d_in    (cq[k]),
      .divisor (hm1),
      .vld     (vld_c[k]),
      .q       (cq[k+1])
    );
  end

  // insets and colour mix products
  item_t       ce;
  logic [10:0] sql, sqr, lft_nxt, rgt_nxt, lft, rgt;
  logic [7:0]  t;
  logic [15:0] mix_nxt [3];
  logic [15:0] mix [3];
  logic        st2_c, st2_d;

  always_comb begin
    ce  = cq[NUM_STEPS];
    sql = ce.rootl[11:1];
    sqr = ce.rootr[11:1];
    unique case (ce.lmode)
      MODE_MITRE: lft_nxt = ce.dyl;
      MODE_ROUND: lft_nxt = rc - sql;
      default:    lft_nxt = '0;
    endcase
    unique case (ce.rmode)
      MODE_MITRE: rgt_nxt = ce.dyr;
      MODE_ROUND: rgt_nxt = rc - sqr;
      default:    rgt_nxt = '0;
    endcase
    t = (rect_height > 12'd1) ? ce.quo[7:0] : 8'd0;
    for (int c = 0; c < 3; c++) begin
      mix_nxt[c] = 16'(color_from[8*c +: 8]) * 16'(8'd255 - t)
                 + 16'(color_to[8*c +: 8]) * 16'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= 1'b0;
    end else if (en[NSTG-2]) begin
      vld_m <= vld[NSTG-3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-2]) begin
      lft   <= lft_nxt;
      rgt   <= rgt_nxt;
      st2_c <= ce.st2;
      for (int c = 0; c < 3; c++)
        mix[c] <= mix_nxt[c];
    end
  end

  // span decision, divide by 255 and output register
  logic [23:0] col;
  logic [16:0] dsum;
  logic [11:0] lr_sum;
  logic [12:0] end_nxt;
  logic [11:0] o_start;
  logic [12:0] o_end;
  logic [23:0] o_color;
  span_status_t o_status, st_nxt;
  logic [11:0] s_nxt;
  logic [12:0] e_nxt;
  logic [23:0] c_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dsum = 17'(mix[c]) + 17'd1 + 17'(mix[c][15:8]);
      col[8*c +: 8] = dsum[15:8];
    end
    lr_sum  = 12'(lft) + 12'(rgt);
    end_nxt = 13'(rect_width - 12'(rgt));
    if (end_nxt > ccols)
      end_nxt = ccols;
    st_nxt = ST_DRAW;
    s_nxt  = 12'(lft);
    e_nxt  = end_nxt;
    c_nxt  = col;
    if (st2_c) begin
      st_nxt = ST_OUT;
      s_nxt  = '0;
      e_nxt  = '0;
      c_nxt  = '0;
    end else if ((lr_sum >= rect_width) || (13'(lft) >= end_nxt)) begin
      st_nxt = ST_EMPTY;
      s_nxt  = '0;
      e_nxt  = '0;
    end
    st2_d = st2_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en[NSTG-1]) begin
      vld_o <= vld[NSTG-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      o_start  <= s_nxt;
      o_end    <= e_nxt;
      o_color  <= c_nxt;
      o_status <= st2_d ? ST_OUT : st_nxt;
    end
  end

  assign out_ch.valid       = vld[NSTG-1];
  assign out_ch.span_start  = o_start;
  assign out_ch.span_end    = o_end;
  assign out_ch.row_color   = o_color;
  assign out_ch.span_status = o_status;

  // a drawn span is never empty
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.span_status == ST_DRAW) |-> out_ch.span_start < out_ch.span_end)
    else $error("drawn span is empty");

  // rows outside the rectangle carry no span and no colour
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.span_status == ST_OUT)
    |-> (out_ch.span_end == '0) && (out_ch.row_color == '0))
    else $error("outside row carries data");

  // a drawn span never passes the clip limit
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.span_status == ST_DRAW) |-> out_ch.span_end <= ccols)
    else $error("span passes clip limit");

  // a stalled result keeps its output register
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(o_end) && $stable(o_color))
    else $error("stalled result changed");

endmodule

/* sv/rrgs_cell.sv */
// one cell of the chain: a square root step on both corners and a divide step
module rrgs_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  rrgs_pkg::item_t d_in,
  input  logic [11:0]     divisor,
  output logic            vld,
  output rrgs_pkg::item_t q
);
  import rrgs_pkg::*;

  localparam int unsigned VBIT = 21 - 2 * STEP;
  localparam int unsigned QBIT = NUM_STEPS - 1 - STEP;

  item_t       nxt;
  logic [13:0] rl, rr;
  logic [12:0] tl, tr;
  logic [21:0] dsh;

  // restoring square root step per corner, restoring divide step for the gradient
  always_comb begin
    nxt = d_in;
    rl  = {d_in.reml[11:0], d_in.vl[VBIT -: 2]};
    tl  = {d_in.rootl[11:0], 1'b0};
    if (14'(tl) < rl) begin
      rl = rl - 14'(tl | 13'd1);
      tl = tl + 13'd2;
    end
    rr  = {d_in.remr[11:0], d_in.vr[VBIT -: 2]};
    tr  = {d_in.rootr[11:0], 1'b0};
    if (14'(tr) < rr) begin
      rr = rr - 14'(tr | 13'd1);
      tr = tr + 13'd2;
    end
    nxt.reml  = rl;
    nxt.rootl = tl;
    nxt.remr  = rr;
    nxt.rootr = tr;
    dsh = 22'(divisor) << QBIT;
    if (22'(d_in.num) >= dsh) begin
      nxt.num       = d_in.num - dsh[19:0];
      nxt.quo[QBIT] = 1'b1;
    end
  end

  // cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

/* dv/rrgs_tb_if.sv */
`timescale 1ns / 1ps
// note: the channel interfaces come from sv/rrgs_if.sv; this file holds the testbench helper types
package rrgs_tb_pkg;
  import rrgs_pkg::*;

  // one expected span result
  typedef struct packed {
    logic [11:0]  span_start;
    logic [12:0]  span_end;
    logic [23:0]  row_color;
    span_status_t span_status;
  } span_t;

  // one row of the directed table, with an optional typed-in result
  typedef struct {
    logic [11:0] row;
    bit          has_span;
    span_t       span;
  } row_req_t;
endpackage

/* dv/tb.sv */
`timescale 1ns / 1ps
// testbench for the rounded rectangle gradient span unit
module tb;
  import rrgs_pkg::*;
  import rrgs_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  rrgs_in_if  in_ch();
  rrgs_out_if out_ch();

  rounded_rect_gradient_spans_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  localparam int unsigned DIM_LIMIT = 4096;
  localparam int unsigned LATENCY   = 14;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // shadow copy of the shape and colour registers
  logic [11:0] sh_width, sh_height;
  logic [10:0] sh_radius;
  logic [7:0]  sh_styles;
  logic [23:0] sh_from, sh_to;
  logic [12:0] sh_clip_c, sh_clip_r;

  span_t       span_q[$];
  int          errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 21, recv_idle = 50;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rounded_rect_gradient_spans_unit test failed");
      $finish;
    end
  end

  // floor square root
  function automatic int unsigned int_root(int unsigned v);
    int unsigned root = 0;
    for (int b = 15; b >= 0; b--)
      if ((root + (1 << b)) * (root + (1 << b)) <= v) root += (1 << b);
    return root;
  endfunction

  function automatic int unsigned side_inset(logic [1:0] style, int unsigned r,
                                             int unsigned depth);
    int unsigned dy;
    if (style == STYLE_SQUARE || r == 0 || depth >= r) return 0;
    dy = r - depth;
    if (style == STYLE_MITRE) return dy;
    return r - int_root(r * r - dy * dy);
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, int unsigned t);
    return 8'((a * (255 - t) + b * t) / 255);
  endfunction

  // expected span of one row from the shadow registers
  function automatic span_t row_span(logic [11:0] row);
    span_t s;
    int unsigned w, h, r, ccols, crows, t, lft, rgt, stop;
    w = sh_width;
    h = sh_height;
    r = sh_radius;
    ccols = (sh_clip_c > DIM_LIMIT) ? DIM_LIMIT : sh_clip_c;
    crows = (sh_clip_r > DIM_LIMIT) ? DIM_LIMIT : sh_clip_r;
    lft = 0;
    rgt = 0;
    s = '0;
    s.span_status = ST_OUT;
    if (w == 0 || h == 0 || row >= h || row >= crows) return s;
    if (r > w / 2) r = w / 2;
    if (r > h / 2) r = h / 2;
    t = (h > 1) ? row * 255 / (h - 1) : 0;
    s.row_color = {mix_channel(sh_from[23:16], sh_to[23:16], t),
                   mix_channel(sh_from[15:8], sh_to[15:8], t),
                   mix_channel(sh_from[7:0], sh_to[7:0], t)};
    s.span_status = ST_EMPTY;
    if (r != 0) begin
      if (row < r) begin
        lft = side_inset(sh_styles[1:0], r, row);
        rgt = side_inset(sh_styles[3:2], r, row);
      end else if (row + r >= h) begin
        lft = side_inset(sh_styles[7:6], r, h - 1 - row);
        rgt = side_inset(sh_styles[5:4], r, h - 1 - row);
      end
    end
    if (lft + rgt >= w) return s;
    stop = w - rgt;
    if (stop > ccols) stop = ccols;
    if (lft >= stop) return s;
    s.span_start = 12'(lft);
    s.span_end = 13'(stop);
    s.span_status = ST_DRAW;
    return s;
  endfunction

  // register write, only while idle
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_WIDTH:  sh_width = val[11:0];
      REG_HEIGHT: sh_height = val[11:0];
      REG_RADIUS: sh_radius = val[10:0];
      REG_STYLES: sh_styles = val[7:0];
      REG_C_FROM: sh_from = val;
      REG_C_TO:   sh_to = val;
      REG_CLIP_C: sh_clip_c = val[12:0];
      default:    sh_clip_r = val[12:0];
    endcase
    @(negedge clk);
  endtask

  task automatic set_shape(int unsigned w, int unsigned h, int unsigned r, int unsigned sty,
                           logic [23:0] cf, logic [23:0] ct, int unsigned cc,
                           int unsigned cr);
    write_reg(REG_WIDTH, 24'(w));
    write_reg(REG_HEIGHT, 24'(h));
    write_reg(REG_RADIUS, 24'(r));
    write_reg(REG_STYLES, 24'(sty));
    write_reg(REG_C_FROM, cf);
    write_reg(REG_C_TO, ct);
    write_reg(REG_CLIP_C, 24'(cc));
    write_reg(REG_CLIP_R, 24'(cr));
    cfg_we <= 1'b0;
  endtask

  // wait until every result is back, plus pipeline drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (span_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // send one row transaction, queue its expected span
  task automatic send_row(logic [11:0] row, bit typed, span_t typed_span);
    span_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pred = row_span(row);
    if (typed && typed_span != pred)
      $display("%0t directed row %0d: table %h predictor %h", $time, row, typed_span, pred);
    span_q.push_back(typed ? typed_span : pred);
    in_ch.valid <= 1'b1;
    in_ch.row_index <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver stalls
  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_idle);

  // check result transactions against the oldest expected span
  always @(posedge clk) begin
    span_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.span_start, out_ch.span_end, out_ch.row_color,
              span_status_t'(out_ch.span_status)};
      if (span_q.size() == 0) begin
        $display("%0t unexpected span: actual %h", $time, got);
        errors++;
      end else begin
        want = span_q.pop_front();
        if (got != want) begin
          $display("%0t span mismatch: expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  row_req_t dir_rows[$];
  span_t    none;

  initial begin
    int unsigned w, h;
    in_ch.valid = 1'b0;
    in_ch.row_index = '0;
    out_ch.ready = 1'b0;
    none = '0;
    sh_width = '0; sh_height = '0; sh_radius = '0; sh_styles = '0;
    sh_from = '0; sh_to = '0; sh_clip_c = 13'(DIM_LIMIT); sh_clip_r = 13'(DIM_LIMIT);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty rectangle after reset
    send_row(12'd0, 1'b1, '{12'd0, 13'd0, 24'd0, ST_OUT});
    send_row(12'hFFF, 1'b1, '{12'd0, 13'd0, 24'd0, ST_OUT});
    drain();
    // square, mitre and round corners, clipped columns, large clip values
    set_shape(20, 20, 6, 8'b11_10_01_00, 24'hFF0000, 24'h00FF80, 13, 8191);
    dir_rows = '{'{12'd0, 1'b0, none}, '{12'd1, 1'b0, none}, '{12'd5, 1'b0, none},
                 '{12'd10, 1'b0, none}, '{12'd14, 1'b0, none}, '{12'd19, 1'b0, none},
                 '{12'd20, 1'b1, '{12'd0, 13'd0, 24'd0, ST_OUT}},
                 '{12'hFFF, 1'b1, '{12'd0, 13'd0, 24'd0, ST_OUT}}};
    foreach (dir_rows[i]) send_row(dir_rows[i].row, dir_rows[i].has_span, dir_rows[i].span);
    drain();
    // corners meet, height one, clipped rows, clipped away
    set_shape(4, 4, 2047, 8'hFF, 24'hFFFFFF, 24'h000000, 0, 2);
    for (int i = 0; i < 4; i++) send_row(12'(i), 1'b0, none);
    drain();
    set_shape(4095, 1, 0, 0, 24'h123456, 24'hFFFFFF, 4096, 4096);
    send_row(12'd0, 1'b0, none);
    send_row(12'd1, 1'b1, '{12'd0, 13'd0, 24'd0, ST_OUT});
    drain();
    set_shape(4095, 4095, 2047, 8'hAA, 24'hFFFFFF, 24'h00FF00, 4096, 4096);
    send_row(12'd0, 1'b0, none);
    send_row(12'd2047, 1'b0, none);
    send_row(12'd4094, 1'b0, none);
    send_row(12'hFFF, 1'b0, none);
    drain();

    // random phases with changing idle patterns
    for (int ph = 0; ph < 60; ph++) begin
      if (ph == 20) begin send_idle = 50; recv_idle = 21; end
      if (ph == 40) begin send_idle = 0; recv_idle = 0; end
      w = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(40);
      h = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(40);
      set_shape(w, h, ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(24),
                $urandom_range(255), 24'($urandom), 24'($urandom),
                ($urandom_range(2) == 0) ? $urandom_range(8191) : $urandom_range(4096),
                ($urandom_range(2) == 0) ? $urandom_range(8191) : $urandom_range(4096));
      for (int i = 0; i < 32; i++)
        send_row(($urandom_range(4) == 0 || h == 0) ? 12'($urandom) :
                 12'($urandom_range(h - 1)), 1'b0, none);
      drain();
    end

    if (errors == 0)
      $display("rounded_rect_gradient_spans_unit test passed");
    else
      $display("rounded_rect_gradient_spans_unit test failed");
    $finish;
  end
endmodule
